@@ design/baby_instruction_step_assert.svh @@
// assertion macros shared by the machine's modules
`ifndef BABY_INSTRUCTION_STEP_ASSERT_SVH
`define BABY_INSTRUCTION_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// condition must hold in the same cycle
`define BIS_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("same-cycle check failed");
// condition must hold in the following cycle
`define BIS_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("next-cycle check failed");
`else
`define BIS_ASSERT_NOW(label, cond, expr)
`define BIS_ASSERT_NEXT(label, cond, expr)
`endif

`endif

@@ design/bis_pkg.sv @@
`timescale 1ns / 1ps
package bis_pkg;

  localparam int unsigned STORE_WORDS = 32;
  localparam int unsigned LINE_W      = $clog2(STORE_WORDS);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FUNC_LSB    = 13;
  localparam int unsigned FUNC_W      = 3;

  // request commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // instruction function codes
  localparam logic [FUNC_W-1:0] FN_JMP     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_JRP     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LDN     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STO     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SUB     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SUB_ALT = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CMP     = 3'd6;
  localparam logic [FUNC_W-1:0] FN_STP     = 3'd7;

  typedef struct packed {
    logic [1:0]        command;
    logic [LINE_W-1:0] word_address;
    logic [WORD_W-1:0] write_word;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] accumulator_value;
    logic [WORD_W-1:0] control_value;
    logic [WORD_W-1:0] read_word;
    logic [FUNC_W-1:0] function_done;
    logic              halted;
  } out_req_t;

  // store port controls from the sequencer
  typedef struct packed {
    logic              re;
    logic [LINE_W-1:0] raddr;
    logic              we;
    logic [LINE_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

@@ design/baby_instruction_step.sv @@
`timescale 1ns / 1ps
// Small stored-program machine: a 32-word store, an accumulator and a control
// counter. Each request either loads a store word, reads one back, or runs one
// instruction, and yields exactly one result holding the machine state. Program
// and data words live in one synchronous store with a single read and a single
// write port, so an instruction runs as instruction fetch, operand read, then
// execute with write back, a read waits on the registered store read, and a
// load or a step after stop finishes at once. A one-entry input buffer and a
// registered output let a new request be accepted while the previous one is
// still running or its result is still stalled.
module baby_instruction_step import bis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic              buf_valid_q;
  in_req_t           buf_q;
  logic              item_take;
  logic              res_ready;
  logic              res_valid;
  out_req_t          res;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata;
  logic              out_valid_q;
  out_req_t          out_q;

  assign in_stall_o = buf_valid_q && !item_take;
  assign res_ready  = !out_valid_q || !out_stall_i;

  // input buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      buf_valid_q <= 1'b1;
    end else if (item_take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      buf_q <= in_req_i;
    end
  end

  bis_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (buf_valid_q),
    .item_i       (buf_q),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_o        (mem_req),
    .rdata_i      (rdata)
  );

  bis_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ design/bis_store.sv @@
`timescale 1ns / 1ps
`include "baby_instruction_step_assert.svh"
module bis_store import bis_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0]      mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] valid_q;
  logic [WORD_W-1:0]      rdata_q;

  // line written since reset; unwritten lines read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // synchronous write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

  `BIS_ASSERT_NEXT(a_write_marks_valid, req_i.we, valid_q[$past(req_i.waddr)])
  `BIS_ASSERT_NEXT(a_read_unwritten_zero, req_i.re && !valid_q[req_i.raddr], rdata_q == '0)
  `BIS_ASSERT_NOW(a_valid_never_clears, $past(valid_q) != '0, (valid_q & $past(valid_q)) == $past(valid_q))

endmodule

@@ design/bis_core.sv @@
`timescale 1ns / 1ps
`include "baby_instruction_step_assert.svh"
module bis_core import bis_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  in_req_t           item_i,
  output logic              item_take_o,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output out_req_t          res_o,
  output mem_req_t          mem_o,
  input  logic [WORD_W-1:0] rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FETCH,
    S_OPER
  } state_e;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] pc_q, pc_d;
  logic              halt_q, halt_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [WORD_W-1:0] pc_inc;
  logic              is_write, is_read, is_run;

  assign pc_inc   = pc_q + WORD_W'(1);
  assign is_write = item_i.command == CMD_WRITE;
  assign is_read  = item_i.command == CMD_READ;
  assign is_run   = (item_i.command == CMD_STEP) && !halt_q;

  // sequencer: store loads and reads, and fetch, operand read, execute and write back
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pc_d        = pc_q;
    halt_d      = halt_q;
    func_d      = func_q;
    line_d      = line_q;
    item_take_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_o       = '0;
    mem_o.wdata = item_i.write_word;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          priority if (is_read) begin
            item_take_o = 1'b1;
            mem_o.re    = 1'b1;
            mem_o.raddr = item_i.word_address;
            state_d     = S_READ;
          end else if (is_run) begin
            item_take_o = 1'b1;
            pc_d        = pc_inc;
            mem_o.re    = 1'b1;
            mem_o.raddr = pc_inc[LINE_W-1:0];
            state_d     = S_FETCH;
          end else begin
            // store load, halted step or unused command finish at once
            if (res_ready_i) begin
              item_take_o = 1'b1;
              res_valid_o = 1'b1;
              mem_o.we    = is_write;
              mem_o.waddr = item_i.word_address;
            end
          end
        end
      end
      S_READ: begin
        if (res_ready_i) begin
          res_valid_o   = 1'b1;
          res_o.read_word = rdata_i;
          state_d       = S_IDLE;
        end
      end
      S_FETCH: begin
        // instruction word arrives; start the operand read
        func_d      = rdata_i[FUNC_LSB +: FUNC_W];
        line_d      = rdata_i[LINE_W-1:0];
        mem_o.re    = 1'b1;
        mem_o.raddr = rdata_i[LINE_W-1:0];
        state_d     = S_OPER;
      end
      S_OPER: begin
        if (res_ready_i) begin
          res_valid_o         = 1'b1;
          res_o.function_done = func_q;
          state_d             = S_IDLE;
          unique case (func_q)
            FN_JMP:              pc_d = rdata_i;
            FN_JRP:              pc_d = pc_q + rdata_i;
            FN_LDN:              acc_d = '0 - rdata_i;
            FN_STO: begin
              mem_o.we    = 1'b1;
              mem_o.waddr = line_q;
              mem_o.wdata = acc_q;
            end
            FN_SUB, FN_SUB_ALT:  acc_d = acc_q - rdata_i;
            FN_CMP:              pc_d = acc_q[WORD_W-1] ? pc_q + WORD_W'(1) : pc_q;
            FN_STP:              halt_d = 1'b1;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    res_o.accumulator_value = acc_d;
    res_o.control_value     = pc_d;
    res_o.halted            = halt_d;
  end

  // machine state and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      func_q  <= '0;
      line_q  <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      func_q  <= func_d;
      line_q  <= line_d;
    end
  end

  `BIS_ASSERT_NOW(a_result_has_room, res_valid_o, res_ready_i)
  `BIS_ASSERT_NOW(a_single_port_use, mem_o.we, !mem_o.re)
  `BIS_ASSERT_NEXT(a_fetch_then_operand, state_q == S_FETCH, state_q == S_OPER)
  `BIS_ASSERT_NEXT(a_halt_sticks, halt_q, halt_q)

endmodule

@@ tb/baby_instruction_step_checker.sv @@
`timescale 1ns / 1ps
module baby_instruction_step_checker import bis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       fail_count_o,
  output int       open_count_o
);

  // machine state as the checker sees it
  logic [WORD_W-1:0] line_mem [STORE_WORDS];
  logic [WORD_W-1:0] acc_q;
  logic [WORD_W-1:0] counter_q;
  logic              stopped_q;

  out_req_t result_q [$];
  out_req_t result_exp;
  int       mismatches = 0;
  int       waiting = 0;

  assign fail_count_o = mismatches;
  assign open_count_o = waiting;

  // apply one request to the machine state and return the state it reports
  function automatic out_req_t run_request(in_req_t req);
    out_req_t          res;
    logic [WORD_W-1:0] instr;
    logic [WORD_W-1:0] operand;
    logic [FUNC_W-1:0] fn;
    res = '0;
    case (req.command)
      CMD_WRITE: begin
        line_mem[req.word_address] = req.write_word;
      end
      CMD_READ: begin
        res.read_word = line_mem[req.word_address];
      end
      CMD_STEP: begin
        if (!stopped_q) begin
          counter_q = counter_q + WORD_W'(1);
          instr     = line_mem[counter_q[LINE_W-1:0]];
          fn        = instr[FUNC_LSB +: FUNC_W];
          operand   = line_mem[instr[LINE_W-1:0]];
          case (fn)
            FN_JMP:             counter_q = operand;
            FN_JRP:             counter_q = counter_q + operand;
            FN_LDN:             acc_q = '0 - operand;
            FN_STO:             line_mem[instr[LINE_W-1:0]] = acc_q;
            FN_SUB, FN_SUB_ALT: acc_q = acc_q - operand;
            FN_CMP: begin
              if (acc_q[WORD_W-1]) counter_q = counter_q + WORD_W'(1);
            end
            FN_STP:             stopped_q = 1'b1;
            default: ;
          endcase
          res.function_done = fn;
        end
      end
      default: ;
    endcase
    res.accumulator_value = acc_q;
    res.control_value     = counter_q;
    res.halted            = stopped_q;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      acc_q     = '0;
      counter_q = '0;
      stopped_q = 1'b0;
      result_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(run_request(in_req_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual %h",
                   $time, out_req_i);
          mismatches++;
        end else begin
          result_exp = result_q.pop_front();
          check_field("accumulator_value", result_exp.accumulator_value,
                      out_req_i.accumulator_value);
          check_field("control_value", result_exp.control_value, out_req_i.control_value);
          check_field("read_word", result_exp.read_word, out_req_i.read_word);
          check_field("function_done", WORD_W'(result_exp.function_done),
                      WORD_W'(out_req_i.function_done));
          check_field("halted", WORD_W'(result_exp.halted), WORD_W'(out_req_i.halted));
        end
      end
    end
    waiting = result_q.size();
  end

endmodule

@@ tb/baby_instruction_step_tb.sv @@
`timescale 1ns / 1ps
module baby_instruction_step_tb;
  import bis_pkg::*;

  // command value the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // program layout: code lines, jump pointers, scratch data
  localparam int unsigned JRP_LAST      = 9;
  localparam int unsigned LOOP_FIRST    = 18;
  localparam int unsigned CODE_LAST     = 19;
  localparam int unsigned PTR_FIRST     = 20;
  localparam int unsigned PTR_LAST      = 25;
  localparam int unsigned SCRATCH_FIRST = 26;
  localparam int unsigned PTR_REACH     = 9;

  localparam int ITEMS        = 1400;
  localparam int STEADY_FIRST = 500;
  localparam int STEADY_LAST  = 800;
  localparam int IDLE_LIMIT   = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  int  fail_count;
  int  open_count;
  int  sent_count = 0;
  int  done_count = 0;
  int  idle_cycles = 0;
  int  loads = 0;
  int  steps = 0;
  int  reads = 0;
  int  ignored = 0;
  bit  steady = 1'b0;

  baby_instruction_step u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  baby_instruction_step_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_req_i    (out_req),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side stalls at random outside the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 25);
  end

  // handshake counters and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sent_count <= sent_count + 1;
      if (out_valid && !out_stall) done_count <= done_count + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // instruction word with random filler bits
  function automatic logic [WORD_W-1:0] encode(input logic [FUNC_W-1:0] fn,
                                               input logic [LINE_W-1:0] opnd);
    logic [WORD_W-1:0] w;
    w = $urandom();
    w[FUNC_LSB +: FUNC_W] = fn;
    w[LINE_W-1:0] = opnd;
    return w;
  endfunction

  // instruction that keeps the counter inside the code lines and never stops
  function automatic logic [WORD_W-1:0] code_word(input int unsigned line);
    logic [FUNC_W-1:0] fn;
    logic [LINE_W-1:0] opnd;
    fn = FN_JMP;
    if (line < LOOP_FIRST) begin
      fn = FUNC_W'($urandom_range(FN_JMP, FN_CMP));
      while (fn == FN_JRP && line > JRP_LAST) fn = FUNC_W'($urandom_range(FN_JMP, FN_CMP));
    end
    case (fn)
      FN_JMP, FN_JRP: opnd = LINE_W'($urandom_range(PTR_FIRST, PTR_LAST));
      FN_STO:         opnd = LINE_W'($urandom_range(SCRATCH_FIRST, STORE_WORDS - 1));
      default:        opnd = LINE_W'($urandom_range(0, STORE_WORDS - 1));
    endcase
    return encode(fn, opnd);
  endfunction

  // jump target or offset landing early in the code lines, random upper bits
  function automatic logic [WORD_W-1:0] pointer_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    w[LINE_W-1:0] = LINE_W'($urandom_range(0, PTR_REACH));
    if (w[LINE_W-1:0] == PTR_REACH) w[LINE_W-1:0] = '1;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] layout_word(input int unsigned line);
    if (line <= CODE_LAST) return code_word(line);
    return pointer_word();
  endfunction

  // send one request, with random gaps ahead of it outside the steady stretch
  task automatic issue(input logic [1:0] cmd, input logic [LINE_W-1:0] line,
                       input logic [WORD_W-1:0] data);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{command: cmd, word_address: line, write_word: data};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (cmd)
      CMD_WRITE: loads++;
      CMD_STEP:  steps++;
      CMD_READ:  reads++;
      default:   ignored++;
    endcase
    steady = (loads + steps + reads >= STEADY_FIRST) && (loads + steps + reads < STEADY_LAST);
  endtask

  // hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sent_count != done_count) @(posedge clk);
  endtask

  initial begin
    int unsigned ln;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every function but stop, skip, counter wrap
    issue(CMD_UNUSED, LINE_W'($urandom()), $urandom());
    issue(CMD_READ, 0, 0);
    issue(CMD_WRITE, 30, 32'h8000_0000);
    issue(CMD_WRITE, 31, 32'hFFFF_FFFF);
    issue(CMD_WRITE, 28, 32'd1);
    issue(CMD_WRITE, 27, 32'hFFFF_FFFF);
    issue(CMD_WRITE, 26, 32'd0);
    issue(CMD_WRITE, 0, encode(FN_JMP, 26));
    issue(CMD_WRITE, 1, encode(FN_LDN, 30));
    issue(CMD_WRITE, 2, encode(FN_CMP, 0));
    issue(CMD_WRITE, 3, encode(FN_LDN, 31));
    issue(CMD_WRITE, 4, encode(FN_SUB, 31));
    issue(CMD_WRITE, 5, encode(FN_SUB_ALT, 30));
    issue(CMD_WRITE, 6, encode(FN_CMP, 1));
    issue(CMD_WRITE, 7, encode(FN_STO, 29));
    issue(CMD_WRITE, 8, encode(FN_JRP, 28));
    issue(CMD_WRITE, 10, encode(FN_JMP, 27));
    // lines 1 2 4 5 6 7 8 10 then line 0 after the counter wraps
    repeat (9) issue(CMD_STEP, LINE_W'($urandom()), $urandom());
    issue(CMD_READ, 29, 0);

    // random programs: full load first, then partial rewrites between runs
    for (ln = 0; ln <= PTR_LAST; ln++) issue(CMD_WRITE, LINE_W'(ln), layout_word(ln));
    while (loads + steps + reads < ITEMS) begin
      repeat ($urandom_range(8, 60)) begin
        if ($urandom_range(99) < 12) begin
          case ($urandom_range(0, 2))
            0:       issue(CMD_READ, LINE_W'($urandom()), $urandom());
            1:       issue(CMD_UNUSED, LINE_W'($urandom()), $urandom());
            default: issue(CMD_WRITE,
                           LINE_W'($urandom_range(SCRATCH_FIRST, STORE_WORDS - 1)),
                           $urandom());
          endcase
        end else begin
          issue(CMD_STEP, LINE_W'($urandom()), $urandom());
        end
      end
      if ($urandom_range(99) < 8) drain();
      repeat ($urandom_range(2, 12)) begin
        ln = $urandom_range(0, PTR_LAST);
        issue(CMD_WRITE, LINE_W'(ln), layout_word(ln));
      end
    end

    // stop: every code line halts, then requests after the stop
    drain();
    for (ln = 0; ln <= CODE_LAST; ln++) begin
      issue(CMD_WRITE, LINE_W'(ln),
            encode(FN_STP, LINE_W'($urandom_range(0, STORE_WORDS - 1))));
    end
    repeat (6) issue(CMD_STEP, LINE_W'($urandom()), $urandom());
    issue(CMD_WRITE, LINE_W'(SCRATCH_FIRST), $urandom());
    issue(CMD_READ, LINE_W'(SCRATCH_FIRST), $urandom());
    issue(CMD_UNUSED, LINE_W'($urandom()), $urandom());
    issue(CMD_STEP, LINE_W'($urandom()), $urandom());

    drain();
    repeat (20) @(posedge clk);
    if (open_count != 0) $display("%0d expected results never arrived", open_count);
    $display("covered %0d requests (%0d loads, %0d steps, %0d reads, %0d ignored), %0d results",
             sent_count, loads, steps, reads, ignored, done_count);
    $display("random programs ran every function but stop; the run closed on a stop");
    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ baby_instruction_step.f @@
+incdir+design
design/bis_pkg.sv
design/bis_store.sv
design/bis_core.sv
design/baby_instruction_step.sv
tb/baby_instruction_step_checker.sv
tb/baby_instruction_step_tb.sv
